// File: sv/svpc_pkg.sv
// Shared types, constants and threshold helpers for the sampled-value protection check.
// No dependencies; every other file in sv/ imports this package.
package svpc_pkg;

   localparam int NUM_LANES  = 4;
   localparam int SMP_W      = 16;
   localparam int SEQ_W      = 17;
   localparam int OC_W       = 22;
   localparam int OV_W       = 23;
   localparam int CLR_W      = 16;
   localparam int RAW_W      = 32;
   localparam int OC_LIM_W   = 32;
   localparam int OV_LIM_W   = 34;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   // Scaling divisor: raw milli-units to engineering units
   localparam logic [OC_LIM_W-1:0]        OC_SCALE = 32'd1000;
   localparam logic signed [OV_LIM_W-1:0] OV_SCALE = 34'sd1000;

   // Reset values (limits are pre-scaled: oc 400 -> 401000, ov 2 -> 3000)
   localparam logic [OC_LIM_W-1:0]        OC_LIM_RESET       = 32'd401000;
   localparam logic signed [OV_LIM_W-1:0] OV_LIM_RESET       = 34'sd3000;
   localparam logic [CLR_W-1:0]           CLEAR_PERIOD_RESET = 16'd2000;
   localparam logic [SEQ_W-1:0]           SEQ_MODULUS_RESET  = 17'd4000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OC_THRESHOLD = 2'd0,
      CSR_OV_THRESHOLD = 2'd1,
      CSR_CLEAR_PERIOD = 2'd2,
      CSR_SEQ_MODULUS  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SMP_W-1:0]        smp_cnt;
      logic                    payload_ok;
      logic signed [RAW_W-1:0] i_a;
      logic signed [RAW_W-1:0] i_b;
      logic signed [RAW_W-1:0] i_c;
      logic signed [RAW_W-1:0] i_n;
      logic signed [RAW_W-1:0] v_a;
      logic signed [RAW_W-1:0] v_b;
      logic signed [RAW_W-1:0] v_c;
      logic signed [RAW_W-1:0] v_n;
   } req_type;

   typedef struct packed {
      logic                 seq_ok;
      logic [NUM_LANES-1:0] oc_phase_flags;
      logic [NUM_LANES-1:0] ov_phase_flags;
      logic                 oc_trip_event;
      logic                 ov_trip_event;
      logic                 oc_latched;
      logic                 ov_latched;
      logic                 trip_general;
   } rsp_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [OC_LIM_W-1:0]        oc_lim;
      logic signed [OV_LIM_W-1:0] ov_lim;
      logic [CLR_W-1:0]           clear_period;
      logic [SEQ_W-1:0]           seq_modulus;
   } cfg_type;

   // Lane results held between the lanes and the merge stage
   typedef struct packed {
      logic [SMP_W-1:0]     smp_cnt;
      logic                 payload_ok;
      logic [NUM_LANES-1:0] oc_flags;
      logic [NUM_LANES-1:0] ov_flags;
   } stage_type;

   // trunc(|x|/1000) > t  <=>  |x| >= 1000*(t+1)
   function automatic logic [OC_LIM_W-1:0] oc_limit(input logic [OC_W-1:0] th);
      logic [OC_LIM_W-1:0] ext;
      ext = {{(OC_LIM_W-OC_W){1'b0}}, th} + OC_LIM_W'(1);
      return OC_LIM_W'(ext * OC_SCALE);
   endfunction

   // trunc(v/1000) > t  <=>  v >= 1000*(t+1) for t >= 0, v >= 1000*t + 1 for t < 0
   function automatic logic signed [OV_LIM_W-1:0] ov_limit(input logic [OV_W-1:0] th);
      logic signed [OV_LIM_W-1:0] ext;
      logic signed [OV_LIM_W-1:0] prod;
      ext  = $signed({{(OV_LIM_W-OV_W){th[OV_W-1]}}, th});
      prod = OV_LIM_W'(ext * OV_SCALE);
      if (th[OV_W-1]) begin
         return prod + OV_LIM_W'(1);
      end
      return prod + OV_SCALE;
   endfunction

endpackage

// File: sv/svpc_lane.sv
// One phase lane: overcurrent and overvoltage tests against pre-scaled limits.
// Depends on svpc_pkg.
module svpc_lane
   import svpc_pkg::*;
(
   input  logic signed [RAW_W-1:0]    i_raw,
   input  logic signed [RAW_W-1:0]    v_raw,
   input  logic [OC_LIM_W-1:0]        oc_lim,
   input  logic signed [OV_LIM_W-1:0] ov_lim,
   output logic                       oc_flag,
   output logic                       ov_flag
);

   logic [RAW_W-1:0]           i_mag;
   logic signed [OV_LIM_W-1:0] v_ext;

   // Take the current magnitude; the most negative value maps to 2^31
   assign i_mag = i_raw[RAW_W-1] ? (~i_raw + RAW_W'(1)) : i_raw;

   // Compare magnitude against the scaled overcurrent limit
   assign oc_flag = ({{(OC_LIM_W-RAW_W){1'b0}}, i_mag} >= oc_lim);

   // Compare sign-extended voltage against the scaled overvoltage limit
   assign v_ext   = $signed({{(OV_LIM_W-RAW_W){v_raw[RAW_W-1]}}, v_raw});
   assign ov_flag = (v_ext >= ov_lim);

endmodule

// File: sv/svpc_merge.sv
// Merge stage: sequence check, trip latches, clearing counter and result register.
// Depends on svpc_pkg.
module svpc_merge
   import svpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      stage_valid,
   input  stage_type stage,
   input  cfg_type   cfg,
   input  logic      rsp_stall,
   output logic      stage_take,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   logic             synced_ff, synced_in;
   logic [SEQ_W-1:0] expected_ff, expected_in;
   logic             oc_latch_ff, oc_latch_in;
   logic             ov_latch_ff, ov_latch_in;
   logic [CLR_W-1:0] frame_cnt_ff, frame_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [SEQ_W-1:0] expected_inc;
   logic             seq_ok;
   logic [NUM_LANES-1:0] oc_flags, ov_flags;
   logic             oc_event, ov_event;

   // Move the staged request on when the result register is free or being drained
   assign stage_take = stage_valid && (!rsp_valid_ff || !rsp_stall);

   // Check sample counter continuity
   assign expected_inc = expected_ff + SEQ_W'(1);
   always_comb begin
      synced_in   = synced_ff;
      expected_in = expected_ff;
      seq_ok      = 1'b0;
      priority if (!synced_ff) begin
         synced_in   = 1'b1;
         expected_in = {1'b0, stage.smp_cnt} + SEQ_W'(1);
         seq_ok      = 1'b1;
      end else if (expected_ff == {1'b0, stage.smp_cnt}) begin
         expected_in = (expected_inc == cfg.seq_modulus) ? '0 : expected_inc;
         seq_ok      = 1'b1;
      end else begin
         synced_in = 1'b0;
      end
   end

   // Combine lane flags, set the latches, then apply the periodic clear
   always_comb begin
      oc_flags     = stage.payload_ok ? stage.oc_flags : '0;
      ov_flags     = stage.payload_ok ? stage.ov_flags : '0;
      oc_event     = 1'b0;
      ov_event     = 1'b0;
      oc_latch_in  = oc_latch_ff;
      ov_latch_in  = ov_latch_ff;
      frame_cnt_in = frame_cnt_ff;
      if (stage.payload_ok) begin
         if (|oc_flags) begin
            oc_event    = !oc_latch_ff;
            oc_latch_in = 1'b1;
         end
         if (|ov_flags) begin
            ov_event    = !ov_latch_ff;
            ov_latch_in = 1'b1;
         end
         if (frame_cnt_ff == cfg.clear_period) begin
            oc_latch_in = 1'b0;
         end
         if (frame_cnt_ff >= cfg.clear_period) begin
            ov_latch_in  = 1'b0;
            frame_cnt_in = '0;
         end else begin
            frame_cnt_in = frame_cnt_ff + CLR_W'(1);
         end
      end
   end

   // Assemble the result
   always_comb begin
      rsp_in.seq_ok         = seq_ok;
      rsp_in.oc_phase_flags = oc_flags;
      rsp_in.ov_phase_flags = ov_flags;
      rsp_in.oc_trip_event  = oc_event;
      rsp_in.ov_trip_event  = ov_event;
      rsp_in.oc_latched     = oc_latch_in;
      rsp_in.ov_latched     = ov_latch_in;
      rsp_in.trip_general   = oc_latch_in || ov_latch_in;
   end

   // Hold the result while stalled, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff    <= 1'b0;
         expected_ff  <= '0;
         oc_latch_ff  <= 1'b0;
         ov_latch_ff  <= 1'b0;
         frame_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (stage_take) begin
            synced_ff    <= synced_in;
            expected_ff  <= expected_in;
            oc_latch_ff  <= oc_latch_in;
            ov_latch_ff  <= ov_latch_in;
            frame_cnt_ff <= frame_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/sampled_value_protection_check.sv
// Sampled-value protection check: top level with configuration registers,
// lane stage and merge stage. Depends on svpc_pkg, svpc_lane and svpc_merge.
//
// Usage:
//   req_*  : one sampled-value frame per request (sample counter, payload flag,
//            four currents, four voltages). Accepted when req_valid && !req_stall.
//   rsp_*  : one result per request, in order. Taken when rsp_valid && !rsp_stall.
//   csr_*  : register writes (index 0 oc_threshold, 1 ov_threshold,
//            2 clear_period, 3 seq_modulus); csr_ready is always high.
//            Thresholds are pre-scaled by 1000 on write, so write only while idle.
// Path: an accepted request is registered in the lane stage, then in the result
//   register that drives rsp_*; a stall can hold it in either register.
// Throughput: one request per cycle while rsp_* is not stalled; four phase lanes
//   test every phase of a frame in parallel, and the merge stage updates the
//   sequence and trip state once per request it takes.
// Stall: a stalled result holds in the output register while one more request
//   is taken into the lane stage; req_stall rises only when both are full.
// Reset (synchronous, active high): registers return to 400, 2, 2000 and 4000,
//   sequence sync is dropped, trip latches and frame counter clear.
module sampled_value_protection_check
   import svpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type              cfg_ff, cfg_in;
   stage_type            stage_ff, stage_in;
   logic                 stage_valid_ff, stage_valid_in;
   logic                 stage_take;
   logic                 req_accept;
   logic [NUM_LANES-1:0] oc_flag, ov_flag;
   logic signed [RAW_W-1:0] i_raw [NUM_LANES];
   logic signed [RAW_W-1:0] v_raw [NUM_LANES];

   // Register writes, limits scaled on the way in
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_OC_THRESHOLD: cfg_in.oc_lim       = oc_limit(csr_data[OC_W-1:0]);
            CSR_OV_THRESHOLD: cfg_in.ov_lim       = ov_limit(csr_data[OV_W-1:0]);
            CSR_CLEAR_PERIOD: cfg_in.clear_period = csr_data[CLR_W-1:0];
            CSR_SEQ_MODULUS:  cfg_in.seq_modulus  = csr_data[SEQ_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.oc_lim       <= OC_LIM_RESET;
         cfg_ff.ov_lim       <= OV_LIM_RESET;
         cfg_ff.clear_period <= CLEAR_PERIOD_RESET;
         cfg_ff.seq_modulus  <= SEQ_MODULUS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Spread the phases over the lanes
   assign i_raw[0] = req_data.i_a;
   assign i_raw[1] = req_data.i_b;
   assign i_raw[2] = req_data.i_c;
   assign i_raw[3] = req_data.i_n;
   assign v_raw[0] = req_data.v_a;
   assign v_raw[1] = req_data.v_b;
   assign v_raw[2] = req_data.v_c;
   assign v_raw[3] = req_data.v_n;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      svpc_lane u_lane (
         .i_raw   (i_raw[g]),
         .v_raw   (v_raw[g]),
         .oc_lim  (cfg_ff.oc_lim),
         .ov_lim  (cfg_ff.ov_lim),
         .oc_flag (oc_flag[g]),
         .ov_flag (ov_flag[g])
      );
   end

   // Accept a request whenever the lane stage is empty or draining
   assign req_stall  = stage_valid_ff && !stage_take;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      stage_in.smp_cnt    = req_data.smp_cnt;
      stage_in.payload_ok = req_data.payload_ok;
      stage_in.oc_flags   = oc_flag;
      stage_in.ov_flags   = ov_flag;
      stage_valid_in      = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_take) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
   end

   // Merge lane results into sequence and trip state
   svpc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .stage       (stage_ff),
      .cfg         (cfg_ff),
      .rsp_stall   (rsp_stall),
      .stage_take  (stage_take),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // An accepted request always lands in the lane stage
   a_accept_stages: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> stage_valid_ff)
      else $error("accepted request not held in lane stage");

   // A staged request that moves on always produces a result
   a_take_result: assert property (@(posedge clock) disable iff (reset)
      stage_take |=> rsp_valid)
      else $error("staged request lost before result register");

   // A trip event needs at least one flagged phase
   a_oc_event_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.oc_trip_event) |-> (rsp_data.oc_phase_flags != '0))
      else $error("overcurrent event without flagged phase");

   a_ov_event_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ov_trip_event) |-> (rsp_data.ov_phase_flags != '0))
      else $error("overvoltage event without flagged phase");

endmodule
